// ===== design/sil_pkg.sv =====
// sil_pkg: shared constants and types for the serial image loader
// no dependencies; used by sil_core, serial_image_loader and the checker

package sil_pkg;

   // default number of progress leds
   localparam int NumLedsDefault = 8;

   // header layout: four size bytes, then four address bytes
   localparam logic [3:0] SizeBytes = 4'd4;
   localparam logic [3:0] HdrBytes  = 4'd8;

   // led codes shown while the header comes in
   localparam logic [7:0] LedSizePhase = 8'h04;
   localparam logic [7:0] LedAddrPhase = 8'h08;

   // one result beat
   typedef struct packed {
      logic        mem_write;
      logic [31:0] mem_addr;
      logic [7:0]  mem_data;
      logic [7:0]  leds;
      logic        done_res;
      logic [31:0] entry_address;
   } rsp_type;

endpackage

// ===== design/sil_channels.sv =====
// sil_channels: valid/ready channels of the serial image loader
// depends on nothing; used by serial_image_loader and its environment

interface sil_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sil_rsp_if;
   logic        valid;
   logic        ready;
   logic        mem_write;
   logic [31:0] mem_addr;
   logic [7:0]  mem_data;
   logic [7:0]  leds;
   logic        done_res;
   logic [31:0] entry_address;

   modport source (output valid, output mem_write, output mem_addr, output mem_data,
                   output leds, output done_res, output entry_address, input ready);
   modport sink   (input valid, input mem_write, input mem_addr, input mem_data,
                   input leds, input done_res, input entry_address, output ready);
endinterface

// ===== design/serial_image_loader.sv =====
// serial_image_loader: top level, input register, loader core, result register
// depends on sil_pkg, sil_channels and sil_core

//  channel    dir   payload                                    role
//  req_chan   in    rx_byte                                    received serial bytes
//  rsp_chan   out   mem_write mem_addr mem_data leds           one result beat per byte
//                   done_res entry_address
//
// one beat in, one beat out; a byte goes from req to rsp through the input register,
// then core logic into the result register
// sustained rate is one byte per cycle while rsp_chan is ready
// reset is synchronous, active high; it clears the handshake and header state
// a stalled rsp_chan holds its beat; req_chan keeps taking beats as long as
// the input register can move on, so it stalls only when both stages are full

module serial_image_loader
   import sil_pkg::*;
#(
   parameter int NUM_LEDS = NumLedsDefault
) (
   input logic        clock,
   input logic        reset,
   sil_req_if.sink    req_chan,
   sil_rsp_if.source  rsp_chan
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type result_ff;
   rsp_type core_result;

   // core consumes the held byte when the result register is free or draining
   logic advance;
   logic req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   sil_core #(
      .NUM_LEDS (NUM_LEDS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance) begin
         result_ff <= core_result;
      end
   end

   // result beat to the port
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.mem_write     = result_ff.mem_write;
   assign rsp_chan.mem_addr      = result_ff.mem_addr;
   assign rsp_chan.mem_data      = result_ff.mem_data;
   assign rsp_chan.leds          = result_ff.leds;
   assign rsp_chan.done_res      = result_ff.done_res;
   assign rsp_chan.entry_address = result_ff.entry_address;

   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("core result lost on advance");

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input byte dropped");

   a_stalled_beat_kept: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> out_valid_ff && $stable(result_ff))
      else $error("stalled result beat changed");

endmodule

// ===== design/sil_core.sv =====
// sil_core: loader state and per-byte result logic
// depends on sil_pkg

module sil_core
   import sil_pkg::*;
#(
   parameter int NUM_LEDS = NumLedsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] rx_byte,
   output rsp_type    result
);

   // progress kept scaled by the led count: shift when (count+1)*n > size
   localparam int ScW  = 32 + $clog2(NUM_LEDS + 1);
   localparam int LedW = (NUM_LEDS > 8) ? NUM_LEDS : 8;

   logic [3:0]          header_count_ff, header_count_in;
   logic [31:0]         image_size_ff, image_size_in;
   logic [31:0]         base_address_ff, base_address_in;
   logic [31:0]         byte_index_ff, byte_index_in;
   logic [ScW-1:0]      progress_ff, progress_in;
   logic [NUM_LEDS-1:0] led_ff, led_in;

   logic [3:0]     header_next;
   logic [ScW-1:0] progress_next;
   logic [LedW-1:0] led_ext;
   logic           show_pattern;

   always_comb begin
      header_count_in = header_count_ff;
      image_size_in   = image_size_ff;
      base_address_in = base_address_ff;
      byte_index_in   = byte_index_ff;
      progress_in     = progress_ff;
      led_in          = led_ff;
      result          = '0;
      show_pattern    = 1'b0;
      header_next     = header_count_ff + 4'd1;
      progress_next   = progress_ff + ScW'(NUM_LEDS);

      if (header_count_ff < HdrBytes) begin
         if (header_count_ff < SizeBytes) begin
            image_size_in = {image_size_ff[23:0], rx_byte};
         end else begin
            base_address_in = {base_address_ff[23:0], rx_byte};
         end
         header_count_in = header_next;
         if (header_next < SizeBytes) begin
            result.leds = LedSizePhase;
         end else if (header_next < HdrBytes) begin
            result.leds = LedAddrPhase;
         end else if (image_size_in == 32'd0) begin
            // empty image: done right after the header
            result.done_res      = 1'b1;
            result.entry_address = base_address_in;
            header_count_in      = '0;
         end else begin
            led_in        = '1;
            byte_index_in = '0;
            progress_in   = '0;
            show_pattern  = 1'b1;
         end
      end else begin
         result.mem_write = 1'b1;
         result.mem_addr  = base_address_ff + byte_index_ff;
         result.mem_data  = rx_byte;
         if (progress_next + ScW'(NUM_LEDS) > ScW'(image_size_ff)) begin
            progress_in = '0;
            led_in      = led_ff << 1;
         end else begin
            progress_in = progress_next;
         end
         byte_index_in = byte_index_ff + 32'd1;
         if (byte_index_in >= image_size_ff) begin
            result.done_res      = 1'b1;
            result.entry_address = base_address_ff;
            header_count_in      = '0;
         end else begin
            show_pattern = 1'b1;
         end
      end

      led_ext = LedW'(led_in);
      if (show_pattern) begin
         result.leds = led_ext[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= '0;
         byte_index_ff   <= '0;
         progress_ff     <= '0;
      end else if (advance) begin
         header_count_ff <= header_count_in;
         byte_index_ff   <= byte_index_in;
         progress_ff     <= progress_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         image_size_ff   <= image_size_in;
         base_address_ff <= base_address_in;
         led_ff          <= led_in;
      end
   end

   a_header_range: assert property (@(posedge clock) disable iff (reset)
      header_count_ff <= HdrBytes)
      else $error("header count beyond header length");

   a_header_no_write: assert property (@(posedge clock) disable iff (reset)
      advance && (header_count_ff < HdrBytes) |-> !result.mem_write)
      else $error("memory write during header");

   a_done_rearms: assert property (@(posedge clock) disable iff (reset)
      advance && result.done_res |=> header_count_ff == '0)
      else $error("loader did not re-arm after done");

endmodule

// ===== dv/sil_load_checker.sv =====
// sil_load_checker: watches both channels of the serial image loader, predicts each result beat
// depends on sil_pkg and sil_channels; instantiated by serial_image_loader_test

`timescale 1ns / 100ps

module sil_load_checker
   import sil_pkg::*;
#(
   parameter int NumLeds = NumLedsDefault
) (
   input  logic clock,
   input  logic reset,
   sil_req_if   req_mon,
   sil_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_beats
);

   localparam logic [31:0] LedMask = 32'((64'd1 << NumLeds) - 64'd1);

   // shadow of the loader state
   logic [3:0]  hdr_taken;
   logic [31:0] size_reg;
   logic [31:0] dest_reg;
   logic [31:0] payload_cnt;
   logic [31:0] led_tick;
   logic [31:0] led_shadow;

   rsp_type expected_q[$];

   initial begin
      mismatch_count = 0;
      pending_beats  = 0;
   end

   function automatic void rearm_loader();
      hdr_taken   = '0;
      size_reg    = '0;
      dest_reg    = '0;
      payload_cnt = '0;
      led_tick    = '0;
      led_shadow  = 32'(LedSizePhase);
   endfunction

   // advance the shadow state by one received byte, return the beat it causes
   function automatic rsp_type load_byte(input logic [7:0] b);
      rsp_type     r;
      logic [31:0] per_led;
      r = '0;
      if (hdr_taken < HdrBytes) begin
         if (hdr_taken < SizeBytes) begin
            size_reg = {size_reg[23:0], b};
         end else begin
            dest_reg = {dest_reg[23:0], b};
         end
         hdr_taken++;
         if (hdr_taken == SizeBytes) begin
            led_shadow = 32'(LedAddrPhase);
         end else if (hdr_taken == HdrBytes) begin
            if (size_reg == '0) begin
               r.done_res      = 1'b1;
               r.entry_address = dest_reg;
               rearm_loader();
               return r;
            end
            led_shadow = LedMask;
         end
         r.leds = led_shadow[7:0];
         return r;
      end
      per_led     = size_reg / NumLeds;
      r.mem_write = 1'b1;
      r.mem_addr  = dest_reg + payload_cnt;
      r.mem_data  = b;
      led_tick++;
      if (led_tick >= per_led) begin
         led_tick   = '0;
         led_shadow = (led_shadow << 1) & LedMask;
      end
      payload_cnt++;
      if (payload_cnt >= size_reg) begin
         r.done_res      = 1'b1;
         r.entry_address = dest_reg;
         rearm_loader();
      end else begin
         r.leds = led_shadow[7:0];
      end
      return r;
   endfunction

   task automatic compare_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         rearm_loader();
         expected_q.delete();
      end else begin
         // result side first: a beat taken now cannot stem from a byte taken at this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result beat with nothing expected, leds %h done %b",
                           $time, rsp_mon.leds, rsp_mon.done_res);
               end
            end else begin
               want = expected_q.pop_front();
               compare_field("mem_write", 32'(want.mem_write), 32'(rsp_mon.mem_write));
               compare_field("mem_addr", want.mem_addr, rsp_mon.mem_addr);
               compare_field("mem_data", 32'(want.mem_data), 32'(rsp_mon.mem_data));
               compare_field("leds", 32'(want.leds), 32'(rsp_mon.leds));
               compare_field("done_res", 32'(want.done_res), 32'(rsp_mon.done_res));
               compare_field("entry_address", want.entry_address, rsp_mon.entry_address);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_q.push_back(load_byte(req_mon.rx_byte));
         end
      end
      pending_beats = expected_q.size();
   end

endmodule

// ===== dv/serial_image_loader_test.sv =====
// serial_image_loader_test: stimulus and verdict for the serial image loader
// depends on sil_pkg, sil_channels, serial_image_loader and sil_load_checker

`timescale 1ns / 100ps

module serial_image_loader_test;
   import sil_pkg::*;

   localparam int NumLeds    = NumLedsDefault;
   localparam int CycleLimit = 200000;

   logic clock;
   logic reset;

   sil_req_if req_bus ();
   sil_rsp_if rsp_bus ();

   int mismatch_count;
   int pending_beats;
   int sent_count;
   int cycle_count;

   // idle rates in percent per beat, set per image by the stimulus process
   int req_idle_pct;
   int rsp_idle_pct;

   serial_image_loader #(
      .NUM_LEDS (NumLeds)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   sil_load_checker #(
      .NumLeds (NumLeds)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_beats  (pending_beats)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost beat ends here
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: ready drops in short random bursts, never in calm stretches
   initial begin : drain
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // one byte beat; called at a falling edge, returns at the falling edge after acceptance
   // valid stays high on return so back-to-back beats need no second assignment
   task automatic send_byte(input logic [7:0] b);
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      sent_count++;
   endtask

   // big-endian size, big-endian destination, then body random payload bytes
   task automatic send_image(input logic [31:0] size, input logic [31:0] dest, input int body);
      for (int i = 3; i >= 0; i--) send_byte(size[8*i +: 8]);
      for (int i = 3; i >= 0; i--) send_byte(dest[8*i +: 8]);
      for (int i = 0; i < body; i++) send_byte(8'($urandom_range(0, 255)));
   endtask

   // drop valid and hold off until every predicted beat has come back
   task automatic drain_pending();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_beats != 0);
   endtask

   initial begin : stimulus
      logic [31:0] size;
      logic [31:0] dest;
      int          kind;
      int          image_no;

      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      req_idle_pct    = 0;
      rsp_idle_pct    = 0;
      sent_count      = 0;
      image_no        = 0;
      reset           = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty image finishes on the last header byte, entry at the top of memory
      send_image(32'h0000_0000, 32'hFFFF_FFFF, 0);
      // directed: image under eight bytes shifts the leds on every byte,
      // destination near the top so the write address wraps past zero
      send_image(32'h0000_0003, 32'hFFFF_FFFE, 0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hA5);

      // random images, mostly small, with idle rates that change per image
      while (sent_count < 2000) begin
         image_no++;
         if (sent_count > 1600) begin
            // closing stretch runs flat out on both sides
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            rsp_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         end

         // empty-pipeline check: let the pipeline run dry before images 10 and 20
         if (image_no == 10 || image_no == 20) begin
            drain_pending();
         end

         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            size = 32'h0;
         end else if (kind <= 2) begin
            size = $urandom_range(1, 7);
         end else if (kind <= 4) begin
            size = $urandom_range(65, 400);
         end else begin
            size = $urandom_range(8, 64);
         end

         if ($urandom_range(0, 3) == 0) begin
            dest = {24'hFF_FFFF, 8'($urandom_range(0, 255))};
         end else begin
            dest = $urandom;
         end

         send_image(size, dest, int'(size));
      end

      // last image: huge size with a nonzero top size byte, cut off after 20 payload bytes
      size = {8'($urandom_range(1, 255)), 24'($urandom)};
      send_image(size, $urandom, 20);

      // wait out the tail, then let the pipeline settle before the verdict
      drain_pending();
      repeat (8) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
